// ===== rtl/lssg_pkg.sv =====
// ----------------------------------------------------------------------------
// lssg_pkg
// Types and constants shared by the local-step shuffle generator modules.
// ----------------------------------------------------------------------------
package lssg_pkg;

    localparam int WORD_W      = 8;
    localparam int NUM_CHUNKS  = 8;
    localparam int CHUNK_IDX_W = 3;

    // Command codes on the input channel.
    localparam logic CMD_RESTART = 1'b0;
    localparam logic CMD_DRAW    = 1'b1;

    // Phase codes carried with every result word.
    localparam logic [1:0] PHASE_INITIAL  = 2'd0;
    localparam logic [1:0] PHASE_EXCLUDED = 2'd1;
    localparam logic [1:0] PHASE_ALL      = 2'd2;

    // Configuration register indexes (byte address is 8 times the index).
    localparam logic [1:0] REG_ITEM_COUNT    = 2'd0;
    localparam logic [1:0] REG_MAX_STEP      = 2'd1;
    localparam logic [1:0] REG_EXCLUDED_MASK = 2'd2;
    localparam logic [1:0] REG_START_VALUE   = 2'd3;

    localparam logic [6:0] ITEM_COUNT_RESET  = 7'd64;
    localparam logic [6:0] START_VALUE_RESET = 7'h7F;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_REFILL,
        ST_POP,
        ST_POP_END,
        ST_MOD,
        ST_WALK
    } state_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t op;
        word_t   a;
        word_t   b;
    } alu_req_t;

    typedef struct packed {
        word_t sum;
        logic  zero;
    } alu_rsp_t;

    typedef struct packed {
        logic [6:0]  item_count;
        logic [5:0]  max_step;
        logic [63:0] excluded_mask;
        logic [6:0]  start_value;
    } cfg_t;

endpackage

// ===== rtl/lssg_alu.sv =====
// ----------------------------------------------------------------------------
// lssg_alu
// Shared signed adder/subtractor used by every step of the sequencer.
// ----------------------------------------------------------------------------
module lssg_alu
    import lssg_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    word_t sum;

    always_comb
    begin
        unique case (req.op)
            ALU_ADD: sum = req.a + req.b;
            ALU_SUB: sum = req.a - req.b;
            default: sum = req.a;
        endcase
    end

    assign rsp.sum  = sum;
    assign rsp.zero = (sum == '0);

endmodule

// ===== rtl/lssg_cfg.sv =====
// ----------------------------------------------------------------------------
// lssg_cfg
// APB register bank: item count, step limit, exclusion mask, start value.
// ----------------------------------------------------------------------------
module lssg_cfg
    import lssg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [6:0]  item_count_reg;
    logic [5:0]  max_step_reg;
    logic [63:0] excluded_mask_reg;
    logic [6:0]  start_value_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_count_reg    <= ITEM_COUNT_RESET;
            max_step_reg      <= '0;
            excluded_mask_reg <= '0;
            start_value_reg   <= START_VALUE_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_ITEM_COUNT:    item_count_reg    <= pwdata[6:0];
                REG_MAX_STEP:      max_step_reg      <= pwdata[5:0];
                REG_EXCLUDED_MASK: excluded_mask_reg <= pwdata;
                REG_START_VALUE:   start_value_reg   <= pwdata[6:0];
                default:           item_count_reg    <= item_count_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_ITEM_COUNT:    prdata = 64'(item_count_reg);
            REG_MAX_STEP:      prdata = 64'(max_step_reg);
            REG_EXCLUDED_MASK: prdata = excluded_mask_reg;
            REG_START_VALUE:   prdata = 64'(start_value_reg);
            default:           prdata = '0;
        endcase
    end

    assign cfg.item_count    = item_count_reg;
    assign cfg.max_step      = max_step_reg;
    assign cfg.excluded_mask = excluded_mask_reg;
    assign cfg.start_value   = start_value_reg;

endmodule

// ===== rtl/local_step_shuffle_generator_top.sv =====
// Restart: after acceptance the sequencer runs decode, eight popcount chunks and finish, then is ready again.
// Draw: decode, refill check, wrap, walk; the wrap repeats for each correction of
// +/- item count and the walk steps past each placed position it meets; a refill
// into the excluded phase first runs the popcount chunks and finish. A rejected draw gives no word.
// The sequencer's sums run through one shared 8-bit adder, one operation per cycle.
// Reset: placed map cleared, current value 0, phase 2, registers at their reset values.
// ----------------------------------------------------------------------------
// local_step_shuffle_generator_top
// Emits a shuffled sequence over 0..n-1 where each value is a bounded random
// step away from the previous one, using an iterative sequencer.
// ----------------------------------------------------------------------------
module local_step_shuffle_generator_top
    import lssg_pkg::*;
#(
    parameter int MAX_COUNT = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [6:0]  random_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  value,
    output logic [1:0]  phase
);

    localparam int IW   = $clog2(MAX_COUNT);
    localparam int CW   = $clog2(MAX_COUNT + 1);
    localparam int CHW  = (MAX_COUNT + NUM_CHUNKS - 1) / NUM_CHUNKS;
    localparam int PADW = CHW * NUM_CHUNKS;
    localparam int PCW  = $clog2(CHW + 1);
    localparam logic [6:0] MAX_COUNT_7 = 7'(MAX_COUNT);

    cfg_t     cfg;
    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    state_t                 state_reg, state_next;
    logic                   cmd_reg, cmd_next;
    logic [6:0]             rv_reg, rv_next;
    word_t                  step_reg, step_next;
    word_t                  acc_reg, acc_next;
    logic [IW-1:0]          cur_reg, cur_next;
    logic [MAX_COUNT-1:0]   placed_reg, placed_next;
    logic [CW-1:0]          left_reg, left_next;
    logic [1:0]             phase_reg, phase_next;
    logic [CW-1:0]          pop_reg, pop_next;
    logic [CHUNK_IDX_W-1:0] chunk_reg, chunk_next;
    logic                   restart_mode_reg, restart_mode_next;
    logic                   out_valid_reg, out_valid_next;
    logic [5:0]             out_value_reg, out_value_next;
    logic [1:0]             out_phase_reg, out_phase_next;

    logic [CW-1:0]        n_eff;
    logic [CW-1:0]        nm1;
    logic [6:0]           d_eff;
    logic [MAX_COUNT-1:0] cm;
    logic [MAX_COUNT-1:0] excl_n;
    logic [PADW-1:0]      excl_pad;
    logic [CHW-1:0]       chunk;
    logic [PCW-1:0]       chunk_cnt;
    logic [6:0]           restart_sel;
    logic [IW-1:0]        restart_cur;
    logic [IW-1:0]        acc_idx;
    logic                 draw_too_big;
    logic                 step_small;
    logic                 refill_ok;
    logic                 acc_in_range;
    logic                 walk_hit;
    logic                 out_free;

    lssg_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lssg_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // Effective count, step limit and the mask of live positions.
    always_comb
    begin
        priority if (cfg.item_count == '0)
            n_eff = CW'(1);
        else if (cfg.item_count > MAX_COUNT_7)
            n_eff = CW'(MAX_COUNT);
        else
            n_eff = CW'(cfg.item_count);
    end

    assign nm1   = n_eff - CW'(1);
    assign d_eff = (cfg.max_step == '0) ? 7'(n_eff >> 1) : {1'b0, cfg.max_step};

    always_comb
    begin
        for (int i = 0; i < MAX_COUNT; i++)
        begin
            cm[i] = (CW'(i) < n_eff);
        end
    end

    assign excl_n   = cfg.excluded_mask[MAX_COUNT-1:0] & cm;
    assign excl_pad = PADW'(excl_n);
    assign chunk    = excl_pad[chunk_reg * CHW +: CHW];

    always_comb
    begin
        chunk_cnt = '0;
        for (int i = 0; i < CHW; i++)
        begin
            chunk_cnt = chunk_cnt + PCW'(chunk[i]);
        end
    end

    assign restart_sel  = cfg.start_value[6] ? rv_reg : {1'b0, cfg.start_value[5:0]};
    assign restart_cur  = (restart_sel >= 7'(n_eff)) ? IW'(nm1) : IW'(restart_sel);
    assign draw_too_big = ({1'b0, rv_reg} > {d_eff, 1'b0});
    assign step_small   = alu_rsp.zero || (alu_rsp.sum == 8'sd1) || (alu_rsp.sum == -8'sd1);
    assign refill_ok    = (left_reg != '0) && ((~placed_reg & cm) != '0);
    assign acc_in_range = !acc_reg[WORD_W-1] && (acc_reg < $signed(8'(n_eff)));
    assign acc_idx      = acc_reg[IW-1:0];
    assign walk_hit     = !placed_reg[acc_idx];
    assign out_free     = !out_valid_reg || out_ready;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                if (cmd_reg == CMD_RESTART)
                    state_next = ST_POP;
                else if (draw_too_big || step_small)
                    state_next = ST_IDLE;
                else
                    state_next = ST_REFILL;
            end
            ST_REFILL:
            begin
                if (!refill_ok && (phase_reg == PHASE_INITIAL))
                    state_next = ST_POP;
                else
                    state_next = ST_MOD;
            end
            ST_POP:
            begin
                if (chunk_reg == CHUNK_IDX_W'(NUM_CHUNKS - 1))
                    state_next = ST_POP_END;
            end
            ST_POP_END:
            begin
                state_next = restart_mode_reg ? ST_IDLE : ST_REFILL;
            end
            ST_MOD:
            begin
                if (acc_in_range)
                    state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (walk_hit && out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and shared-unit control.
    always_comb
    begin
        cmd_next          = cmd_reg;
        rv_next           = rv_reg;
        step_next         = step_reg;
        acc_next          = acc_reg;
        cur_next          = cur_reg;
        placed_next       = placed_reg;
        left_next         = left_reg;
        phase_next        = phase_reg;
        pop_next          = pop_reg;
        chunk_next        = chunk_reg;
        restart_mode_next = restart_mode_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        out_value_next    = out_value_reg;
        out_phase_next    = out_phase_reg;
        alu_req.op        = ALU_ADD;
        alu_req.a         = acc_reg;
        alu_req.b         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next = command;
                    rv_next  = random_value;
                end
            end
            ST_DECODE:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = $signed({1'b0, rv_reg});
                alu_req.b  = $signed({1'b0, d_eff});
                if (cmd_reg == CMD_RESTART)
                begin
                    cur_next          = restart_cur;
                    pop_next          = '0;
                    chunk_next        = '0;
                    restart_mode_next = 1'b1;
                end
                else
                begin
                    step_next = alu_rsp.sum;
                end
            end
            ST_REFILL:
            begin
                alu_req.op = ALU_ADD;
                alu_req.a  = $signed(8'(cur_reg));
                alu_req.b  = step_reg;
                if (refill_ok)
                begin
                    acc_next = alu_rsp.sum;
                end
                else if (phase_reg == PHASE_INITIAL)
                begin
                    pop_next          = '0;
                    chunk_next        = '0;
                    restart_mode_next = 1'b0;
                end
                else
                begin
                    phase_next  = PHASE_ALL;
                    placed_next = '0;
                    left_next   = n_eff;
                    acc_next    = alu_rsp.sum;
                end
            end
            ST_POP:
            begin
                alu_req.op = ALU_ADD;
                alu_req.a  = $signed(8'(pop_reg));
                alu_req.b  = $signed(8'(chunk_cnt));
                pop_next   = alu_rsp.sum[CW-1:0];
                chunk_next = chunk_reg + CHUNK_IDX_W'(1);
            end
            ST_POP_END:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = $signed(8'(n_eff));
                alu_req.b  = $signed(8'(pop_reg));
                if (restart_mode_reg)
                begin
                    placed_next = excl_n;
                    left_next   = alu_rsp.sum[CW-1:0];
                    phase_next  = PHASE_INITIAL;
                end
                else
                begin
                    placed_next = ~excl_n & cm;
                    left_next   = pop_reg;
                    phase_next  = PHASE_EXCLUDED;
                end
            end
            ST_MOD:
            begin
                // Fold the moved position back into 0..n-1 one count at a time.
                alu_req.op = acc_reg[WORD_W-1] ? ALU_ADD : ALU_SUB;
                alu_req.a  = acc_reg;
                alu_req.b  = $signed(8'(n_eff));
                if (!acc_in_range)
                    acc_next = alu_rsp.sum;
            end
            ST_WALK:
            begin
                alu_req.op = step_reg[WORD_W-1] ? ALU_SUB : ALU_ADD;
                alu_req.a  = acc_reg;
                alu_req.b  = 8'sd1;
                if (walk_hit)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_value_next = 6'(acc_idx);
                        out_phase_next = phase_reg;
                        placed_next    = placed_reg | (MAX_COUNT'(1) << acc_idx);
                        cur_next       = acc_idx;
                        if (left_reg != '0)
                            left_next = left_reg - CW'(1);
                    end
                end
                else if (step_reg[WORD_W-1] && (acc_idx == '0))
                begin
                    acc_next = $signed(8'(nm1));
                end
                else if (!step_reg[WORD_W-1] && (acc_idx == IW'(nm1)))
                begin
                    acc_next = '0;
                end
                else
                begin
                    acc_next = alu_rsp.sum;
                end
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cur_reg          <= '0;
            placed_reg       <= '0;
            left_reg         <= '0;
            phase_reg        <= PHASE_ALL;
            restart_mode_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cur_reg          <= cur_next;
            placed_reg       <= placed_next;
            left_reg         <= left_next;
            phase_reg        <= phase_next;
            restart_mode_reg <= restart_mode_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        rv_reg        <= rv_next;
        step_reg      <= step_next;
        acc_reg       <= acc_next;
        pop_reg       <= pop_next;
        chunk_reg     <= chunk_next;
        out_value_reg <= out_value_next;
        out_phase_reg <= out_phase_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign value     = out_value_reg;
    assign phase     = out_phase_reg;

`ifndef ASSERT_OFF
    // The walk only ever looks at live positions.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> acc_in_range)
        else $error("walk position outside 0..n-1");

    // The refill step must leave at least one unplaced value before the walk.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> ((~placed_reg & cm) != '0))
        else $error("walk started with every value placed");

    // A new word appears only as the walk finishes.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_WALK))
        else $error("result word raised outside the walk");

    // The emitted value is marked placed right after it is loaded.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_WALK) && walk_hit && out_free) |=> placed_reg[cur_reg])
        else $error("emitted value not marked placed");
`endif

endmodule
